// ----- sv/som_neuron_majority_labeler_defines.svh -----
// Assertion macros shared by the labeler modules.
`ifndef SOM_NEURON_MAJORITY_LABELER_DEFINES_SVH
`define SOM_NEURON_MAJORITY_LABELER_DEFINES_SVH

`define SMNL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define SMNL_NEVER(lbl, expr, msg) \
  `SMNL_ASSERT(lbl, !(expr), msg)

`endif

// ----- sv/smnl_pkg.sv -----
package smnl_pkg;

  localparam int CLS_W     = 4;
  localparam int NEURON_W  = 10;
  localparam int CNT_OUT_W = 20;

  localparam logic [CLS_W-1:0] NUM_CLASSES_RST = 4'd12;

  typedef enum logic [1:0] {
    MODE_COUNT = 2'd0,
    MODE_QUERY = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_e;

  typedef struct packed {
    logic [1:0]          mode;
    logic [NEURON_W-1:0] neuron_index;
    logic [CLS_W-1:0]    class_label;
  } in_word_t;

  typedef struct packed {
    logic [CLS_W-1:0]     winning_class;
    logic [CNT_OUT_W-1:0] winning_count;
    logic [CNT_OUT_W-1:0] unlabeled_count;
  } out_word_t;

  typedef struct packed {
    logic             start;
    logic [CLS_W-1:0] ncls;
  } scan_ctl_t;

  typedef struct packed {
    logic             done;
    logic [CLS_W-1:0] best_cls;
  } scan_sts_t;

endpackage

// ----- sv/smnl_vote_mem.sv -----
module smnl_vote_mem #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 320,
  parameter int AW    = 10
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/smnl_class_scan.sv -----
`include "som_neuron_majority_labeler_defines.svh"

module smnl_class_scan #(
  parameter int CLASS_SLOTS = 16,
  parameter int COUNT_BITS  = 20
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  smnl_pkg::scan_ctl_t                    ctl_i,
  input  logic [CLASS_SLOTS-1:0][COUNT_BITS-1:0] row_i,
  output smnl_pkg::scan_sts_t                    sts_o,
  output logic [COUNT_BITS-1:0]                  best_cnt_o
);

  import smnl_pkg::*;

  localparam int SW = $clog2(CLASS_SLOTS);

  logic                  active_q, active_d;
  logic                  done_q, done_d;
  logic [CLS_W-1:0]      cls_q, cls_d;
  logic [CLS_W-1:0]      ncls_q, ncls_d;
  logic [CLS_W-1:0]      best_cls_q, best_cls_d;
  logic [COUNT_BITS-1:0] best_cnt_q, best_cnt_d;
  logic [SW-1:0]         slot;
  logic [COUNT_BITS-1:0] entry;

  assign slot  = SW'(cls_q);
  assign entry = row_i[slot];

  always_comb begin
    active_d   = active_q;
    done_d     = 1'b0;
    cls_d      = cls_q;
    ncls_d     = ncls_q;
    best_cls_d = best_cls_q;
    best_cnt_d = best_cnt_q;
    if (ctl_i.start) begin
      cls_d      = CLS_W'(1);
      ncls_d     = ctl_i.ncls;
      best_cls_d = '0;
      best_cnt_d = '0;
      active_d   = (ctl_i.ncls != '0);
      done_d     = (ctl_i.ncls == '0);
    end else if (active_q) begin
      if (entry > best_cnt_q) begin
        best_cnt_d = entry;
        best_cls_d = cls_q;
      end
      if (cls_q == ncls_q) begin
        active_d = 1'b0;
        done_d   = 1'b1;
      end else begin
        cls_d = cls_q + CLS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      done_q     <= 1'b0;
      cls_q      <= '0;
      ncls_q     <= '0;
      best_cls_q <= '0;
      best_cnt_q <= '0;
    end else begin
      active_q   <= active_d;
      done_q     <= done_d;
      cls_q      <= cls_d;
      ncls_q     <= ncls_d;
      best_cls_q <= best_cls_d;
      best_cnt_q <= best_cnt_d;
    end
  end

  assign sts_o.done     = done_q;
  assign sts_o.best_cls = best_cls_q;
  assign best_cnt_o     = best_cnt_q;

  `SMNL_ASSERT(a_no_class_no_count, best_cls_q == '0 |-> best_cnt_q == '0, "count without class")
  `SMNL_ASSERT(a_last_class_done, active_q && !ctl_i.start && cls_q == ncls_q |=> done_q && !active_q, "scan did not end")
  `SMNL_NEVER(a_done_while_active, done_q && active_q, "scan done while still active")

endmodule

// ----- sv/som_neuron_majority_labeler.sv -----
// Channel  Direction  Payload            Handshake
// in       input      smnl_pkg::in_word_t  in_valid_i / in_stall_o
// out      output     smnl_pkg::out_word_t out_valid_o / out_stall_i
// cfg      input      num_classes        cfg_we_i (no stall)
// A count word is a row read and a saturating write back.
// A query word is resolved by the class compare unit, which walks one
// counter of the row per cycle, classes 1 to num_classes.
// A clear word, and reset, sweep the vote memory one row per cycle over
// all NEURONS rows (1024 by default), during which input words are stalled.
// A finished query result waits in the output register while new words are
// taken; a query reaching its result with the register still full waits.
`include "som_neuron_majority_labeler_defines.svh"

module som_neuron_majority_labeler #(
  parameter int NEURONS     = 1024,
  parameter int CLASS_SLOTS = 16,
  parameter int COUNT_BITS  = 20
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  smnl_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output smnl_pkg::out_word_t out_word_o,
  input  logic                cfg_we_i,
  input  logic [3:0]          cfg_wdata_i
);

  import smnl_pkg::*;

  localparam int AW   = (NEURONS > 1) ? $clog2(NEURONS) : 1;
  localparam int SW   = $clog2(CLASS_SLOTS);
  localparam int ROWW = CLASS_SLOTS * COUNT_BITS;
  localparam logic [AW-1:0]         ClrLast = AW'(NEURONS - 1);
  localparam logic [COUNT_BITS-1:0] CntMax  = '1;

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_MODIFY = 5'b00100,
    ST_SCAN   = 5'b01000,
    ST_RESULT = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  logic [CLS_W-1:0] num_classes_q;
  logic [CLS_W-1:0] ncls;
  logic [AW-1:0]    addr_q, addr_d;
  logic [AW-1:0]    clr_cnt_q, clr_cnt_d;
  logic [SW-1:0]    slot_q, slot_d;
  logic             zero_q, zero_d;
  logic             out_valid_q, out_valid_d;
  out_word_t        out_word_q, out_word_d;
  logic             accept;
  logic             in_range;
  logic             label_ok;

  logic                                   mem_we, mem_re;
  logic [AW-1:0]                          mem_waddr;
  logic [ROWW-1:0]                        mem_wdata, mem_rdata;
  logic [CLASS_SLOTS-1:0][COUNT_BITS-1:0] rd_row, wr_row;

  scan_ctl_t             scan_ctl;
  scan_sts_t             scan_sts;
  logic [COUNT_BITS-1:0] best_cnt;

  assign ncls = (int'(num_classes_q) > CLASS_SLOTS - 1) ? CLS_W'(CLASS_SLOTS - 1)
                                                        : num_classes_q;
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign in_range   = int'(in_word_i.neuron_index) < NEURONS;
  assign label_ok   = in_word_i.class_label <= ncls;
  assign rd_row     = mem_rdata;

  always_comb begin
    wr_row = rd_row;
    if (rd_row[slot_q] != CntMax) begin
      wr_row[slot_q] = rd_row[slot_q] + COUNT_BITS'(1);
    end
  end

  always_comb begin
    state_d     = state_q;
    addr_d      = addr_q;
    clr_cnt_d   = clr_cnt_q;
    slot_d      = slot_q;
    zero_d      = zero_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_word_d  = out_word_q;
    mem_re      = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = addr_q;
    mem_wdata   = wr_row;
    scan_ctl.start = 1'b0;
    scan_ctl.ncls  = ncls;
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        mem_wdata = '0;
        if (clr_cnt_q == ClrLast) begin
          state_d = ST_IDLE;
        end else begin
          clr_cnt_d = clr_cnt_q + AW'(1);
        end
      end
      ST_IDLE: begin
        if (accept) begin
          addr_d = AW'(in_word_i.neuron_index);
          slot_d = SW'(in_word_i.class_label);
          case (in_word_i.mode)
            MODE_COUNT: begin
              if (in_range && label_ok) begin
                mem_re  = 1'b1;
                state_d = ST_MODIFY;
              end
            end
            MODE_QUERY: begin
              zero_d = !in_range;
              if (in_range) begin
                mem_re         = 1'b1;
                scan_ctl.start = 1'b1;
                state_d        = ST_SCAN;
              end else begin
                state_d = ST_RESULT;
              end
            end
            MODE_CLEAR: begin
              clr_cnt_d = '0;
              state_d   = ST_CLEAR;
            end
            default: begin
            end
          endcase
        end
      end
      ST_MODIFY: begin
        mem_we  = 1'b1;
        state_d = ST_IDLE;
      end
      ST_SCAN: begin
        if (scan_sts.done) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          if (zero_q) begin
            out_word_d = '0;
          end else begin
            out_word_d.winning_class   = scan_sts.best_cls;
            out_word_d.winning_count   = CNT_OUT_W'(best_cnt);
            out_word_d.unlabeled_count = CNT_OUT_W'(rd_row[0]);
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      clr_cnt_q     <= '0;
      out_valid_q   <= 1'b0;
      num_classes_q <= NUM_CLASSES_RST;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        num_classes_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q     <= addr_d;
    slot_q     <= slot_d;
    zero_q     <= zero_d;
    out_word_q <= out_word_d;
  end

  smnl_vote_mem #(
    .DEPTH (NEURONS),
    .WIDTH (ROWW),
    .AW    (AW)
  ) u_vote_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (addr_d),
    .rdata_o (mem_rdata)
  );

  smnl_class_scan #(
    .CLASS_SLOTS (CLASS_SLOTS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_class_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (scan_ctl),
    .row_i      (rd_row),
    .sts_o      (scan_sts),
    .best_cnt_o (best_cnt)
  );

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  `SMNL_NEVER(a_rw_overlap, mem_we && mem_re, "memory read and write in one cycle")
  `SMNL_ASSERT(a_scan_done_state, scan_sts.done |-> state_q == ST_SCAN, "scan done outside scan")
  `SMNL_ASSERT(a_clear_ends, state_q == ST_CLEAR && clr_cnt_q == ClrLast |=> state_q == ST_IDLE, "clear sweep did not end")

endmodule

// ----- verif/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import smnl_pkg::*;

  localparam int NEURONS       = 1024;
  localparam int CLASS_SLOTS   = 16;
  localparam int CNT_MAX       = (1 << 20) - 1;
  localparam int SETTLE_CYCLES = 1100;
  localparam int STALL_LIMIT   = 4000;
  localparam int RANDOM_WORDS  = 1100;
  localparam int PHASES        = 6;
  localparam int MAX_REPORTS   = 40;

  localparam logic [1:0] MODE_SPARE = 2'd3;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  in_word_t   in_word_i;
  logic       out_valid_o;
  logic       out_stall_i;
  out_word_t  out_word_o;
  logic       cfg_we_i;
  logic [3:0] cfg_wdata_i;

  som_neuron_majority_labeler dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  bit [19:0]  vote_tab [NEURONS*CLASS_SLOTS];
  logic [3:0] class_limit;
  in_word_t   word_q [$];
  out_word_t  majority_q [$];
  int         err_cnt;
  int         send_idle_pct;
  int         stall_pct;
  int         quiet_cycles;
  int         calm_timer;
  bit         calm;
  bit         word_shown;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS) $display("%0t ns mismatch: %s", $time, msg);
  endtask

  function automatic void vote_apply(input in_word_t w);
    int        base;
    logic [3:0]  best;
    logic [19:0] best_cnt;
    out_word_t r;
    base = int'(w.neuron_index) * CLASS_SLOTS;
    case (w.mode)
      MODE_COUNT: begin
        if (w.class_label <= class_limit &&
            vote_tab[base + int'(w.class_label)] != CNT_MAX)
          vote_tab[base + int'(w.class_label)]++;
      end
      MODE_QUERY: begin
        best     = '0;
        best_cnt = '0;
        for (int c = 1; c <= int'(class_limit); c++) begin
          if (vote_tab[base + c] > best_cnt) begin
            best_cnt = vote_tab[base + c];
            best     = c[3:0];
          end
        end
        r.winning_class   = best;
        r.winning_count   = best_cnt;
        r.unlabeled_count = vote_tab[base];
        majority_q.push_back(r);
      end
      MODE_CLEAR: begin
        foreach (vote_tab[i]) vote_tab[i] = '0;
      end
      default: ;
    endcase
  endfunction

  function automatic void push_word(input logic [1:0] m, input int n, input int l);
    in_word_t w;
    w.mode         = m;
    w.neuron_index = n[9:0];
    w.class_label  = l[3:0];
    word_q.push_back(w);
  endfunction

  function automatic in_word_t random_word(input logic [3:0] lim);
    in_word_t w;
    int       r;
    int       k;
    r = $urandom_range(0, 99);
    if (r < 68) w.mode = MODE_COUNT;
    else if (r < 97) w.mode = MODE_QUERY;
    else if (r < 99) w.mode = MODE_SPARE;
    else w.mode = MODE_CLEAR;
    k = $urandom_range(0, 5);
    if ($urandom_range(0, 99) < 85) w.neuron_index = (k == 5) ? 10'd1023 : 10'(k * 204);
    else w.neuron_index = 10'($urandom_range(0, NEURONS - 1));
    if ($urandom_range(0, 3) != 0) w.class_label = 4'($urandom_range(0, int'(lim)));
    else w.class_label = 4'($urandom_range(0, 15));
    return w;
  endfunction

  task automatic drain;
    while (word_q.size() != 0 || majority_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_class_limit(input logic [3:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    class_limit = v;
  endtask

  always @(negedge clk_i) begin : drive
    if (calm_timer == 0) begin
      calm       = ($urandom_range(0, 3) == 0);
      calm_timer = 48;
    end else begin
      calm_timer--;
    end
    out_stall_i <= !calm && ($urandom_range(0, 99) < stall_pct);
    if (!word_shown) begin
      if (rst_ni && word_q.size() != 0 &&
          (calm || $urandom_range(0, 99) >= send_idle_pct)) begin
        in_word_i  <= word_q[0];
        in_valid_i <= 1'b1;
        word_shown = 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : sample
    out_word_t want;
    bit        moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        vote_apply(in_word_i);
        void'(word_q.pop_front());
        word_shown = 1'b0;
        moved      = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        moved = 1'b1;
        if (majority_q.size() == 0) begin
          report_mismatch("result word with no query outstanding");
        end else begin
          want = majority_q.pop_front();
          if (out_word_o.winning_class !== want.winning_class)
            report_mismatch($sformatf("winning_class %0d, expected %0d",
                                      out_word_o.winning_class, want.winning_class));
          if (out_word_o.winning_count !== want.winning_count)
            report_mismatch($sformatf("winning_count %0d, expected %0d",
                                      out_word_o.winning_count, want.winning_count));
          if (out_word_o.unlabeled_count !== want.unlabeled_count)
            report_mismatch($sformatf("unlabeled_count %0d, expected %0d",
                                      out_word_o.unlabeled_count, want.unlabeled_count));
        end
      end
      if (moved || (word_q.size() == 0 && majority_q.size() == 0)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("tb_top NOT OK");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    logic [3:0] plan [PHASES];
    in_valid_i    = 1'b0;
    in_word_i     = '0;
    out_stall_i   = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    rst_ni        = 1'b0;
    class_limit   = NUM_CLASSES_RST;
    err_cnt       = 0;
    quiet_cycles  = 0;
    calm_timer    = 0;
    calm          = 1'b0;
    word_shown    = 1'b0;
    send_idle_pct = 13;
    stall_pct     = 50;
    plan[0] = 4'd5;
    plan[1] = 4'd15;
    plan[2] = 4'd1;
    plan[3] = 4'd0;
    plan[4] = 4'($urandom_range(2, 14));
    plan[5] = 4'd12;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    drain();

    set_class_limit(4'd3);
    push_word(MODE_QUERY, 0, 0);
    push_word(MODE_COUNT, 0, 0);
    push_word(MODE_COUNT, 0, 2);
    push_word(MODE_COUNT, 0, 1);
    push_word(MODE_QUERY, 0, 0);
    push_word(MODE_COUNT, 0, 4);
    push_word(MODE_COUNT, 0, 15);
    push_word(MODE_COUNT, 0, 3);
    push_word(MODE_COUNT, 0, 3);
    push_word(MODE_QUERY, 0, 0);
    push_word(MODE_COUNT, 1023, 3);
    push_word(MODE_QUERY, 1023, 15);
    push_word(MODE_SPARE, 1023, 15);
    push_word(MODE_QUERY, 1023, 0);
    push_word(MODE_CLEAR, 1023, 15);
    push_word(MODE_QUERY, 0, 0);
    drain();

    set_class_limit(4'd0);
    push_word(MODE_COUNT, 5, 1);
    push_word(MODE_COUNT, 5, 0);
    push_word(MODE_QUERY, 5, 0);
    drain();

    set_class_limit(4'd15);
    push_word(MODE_COUNT, 1023, 15);
    push_word(MODE_COUNT, 1023, 14);
    push_word(MODE_QUERY, 1023, 0);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p / 2)
        0: begin
          send_idle_pct = 13;
          stall_pct     = 50;
        end
        1: begin
          send_idle_pct = 50;
          stall_pct     = 13;
        end
        default: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
      endcase
      set_class_limit(plan[p]);
      for (int i = 0; i < RANDOM_WORDS / PHASES; i++) word_q.push_back(random_word(plan[p]));
      drain();
    end

    if (err_cnt == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
